// ----- hdl/vpid_pkg.sv -----
// Package: types, constants and register map for the velocity PID block.
package vpid_pkg;

	typedef struct packed {
		logic signed [23:0] goal_velocity;
		logic signed [23:0] measured_velocity;
	} vpid_in_t;

	typedef struct packed {
		logic [15:0] duty;
		logic        output_negative;
		logic        over_twice_limit;
		logic        stopped;
	} vpid_out_t;

	typedef enum logic [2:0] {
		REG_RULE_SET  = 3'd0,
		REG_GAIN_P    = 3'd1,
		REG_GAIN_I    = 3'd2,
		REG_GAIN_D    = 3'd3,
		REG_TICK      = 3'd4,
		REG_DWEIGHT   = 3'd5,
		REG_DEADBAND  = 3'd6,
		REG_DUTY_LIM  = 3'd7
	} vpid_reg_t;

	typedef struct packed {
		logic              rule_set;
		logic signed [23:0] gain_p;
		logic signed [23:0] gain_i;
		logic signed [23:0] gain_d;
		logic [15:0]       tick_period;
		logic [15:0]       derivative_weight;
		logic [15:0]       deadband;
		logic [15:0]       duty_limit;
	} vpid_cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_SHAPE,
		ST_DOT,
		ST_INT,
		ST_UP,
		ST_UI,
		ST_UD,
		ST_ACC,
		ST_DUTY,
		ST_OUT
	} vpid_state_t;

	// one step command per datapath phase
	typedef struct packed {
		logic load;
		logic err;
		logic shape;
		logic dot;
		logic integ;
		logic up;
		logic ui;
		logic ud;
		logic acc;
		logic duty;
	} vpid_cmd_t;

	typedef struct packed {
		logic goal_zero;
	} vpid_stat_t;

endpackage

// ----- hdl/vpid_regs.sv -----
// Configuration register file behind the APB-style port.
module vpid_regs import vpid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output vpid_cfg_t   cfg
);
	vpid_cfg_t cfg_q;
	logic      wr;
	vpid_reg_t idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = vpid_reg_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rule_set          <= 1'b0;
			cfg_q.gain_p            <= '0;
			cfg_q.gain_i            <= '0;
			cfg_q.gain_d            <= '0;
			cfg_q.tick_period       <= 16'd6554;
			cfg_q.derivative_weight <= 16'd60713;
			cfg_q.deadband          <= 16'd655;
			cfg_q.duty_limit        <= 16'd255;
		end else if (wr && paddr[1:0] == 2'b00) begin
			unique case (idx)
				REG_RULE_SET: cfg_q.rule_set          <= pwdata[0];
				REG_GAIN_P:   cfg_q.gain_p            <= pwdata[23:0];
				REG_GAIN_I:   cfg_q.gain_i            <= pwdata[23:0];
				REG_GAIN_D:   cfg_q.gain_d            <= pwdata[23:0];
				REG_TICK:     cfg_q.tick_period       <= pwdata[15:0];
				REG_DWEIGHT:  cfg_q.derivative_weight <= pwdata[15:0];
				REG_DEADBAND: cfg_q.deadband          <= pwdata[15:0];
				REG_DUTY_LIM: cfg_q.duty_limit        <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_RULE_SET: prdata = {31'd0, cfg_q.rule_set};
			REG_GAIN_P:   prdata = {{8{cfg_q.gain_p[23]}}, cfg_q.gain_p};
			REG_GAIN_I:   prdata = {{8{cfg_q.gain_i[23]}}, cfg_q.gain_i};
			REG_GAIN_D:   prdata = {{8{cfg_q.gain_d[23]}}, cfg_q.gain_d};
			REG_TICK:     prdata = {16'd0, cfg_q.tick_period};
			REG_DWEIGHT:  prdata = {16'd0, cfg_q.derivative_weight};
			REG_DEADBAND: prdata = {16'd0, cfg_q.deadband};
			REG_DUTY_LIM: prdata = {16'd0, cfg_q.duty_limit};
			default:      prdata = '0;
		endcase
	end
endmodule

// ----- hdl/vpid_ctrl.sv -----
// Sequencer: steps the datapath through one control tick.
module vpid_ctrl import vpid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  vpid_stat_t stat,
	output vpid_cmd_t  cmd
);
	vpid_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_ERR;
				end
			end
			ST_ERR: begin
				cmd.err = 1'b1;
				state_d = stat.goal_zero ? ST_OUT : ST_SHAPE;
			end
			ST_SHAPE: begin cmd.shape = 1'b1; state_d = ST_DOT; end
			ST_DOT:   begin cmd.dot = 1'b1;   state_d = ST_INT; end
			ST_INT:   begin cmd.integ = 1'b1; state_d = ST_UP; end
			ST_UP:    begin cmd.up = 1'b1;    state_d = ST_UI; end
			ST_UI:    begin cmd.ui = 1'b1;    state_d = ST_UD; end
			ST_UD:    begin cmd.ud = 1'b1;    state_d = ST_ACC; end
			ST_ACC:   begin cmd.acc = 1'b1;   state_d = ST_DUTY; end
			ST_DUTY:  begin cmd.duty = 1'b1;  state_d = ST_OUT; end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ----- hdl/vpid_dp.sv -----
// Datapath: error shaping, shared multiplier, integrator and accumulator.
module vpid_dp import vpid_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int MAG_CLAMP = 150
) (
	input  logic       clk,
	input  logic       arst_n,
	input  vpid_in_t   din,
	input  vpid_cfg_t  cfg,
	input  vpid_cmd_t  cmd,
	output vpid_stat_t stat,
	output vpid_out_t  dout
);
	localparam logic signed [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] ACC_MIN = {1'b1, 47'd0};
	localparam logic signed [39:0] INT_MAX = {1'b0, {39{1'b1}}};
	localparam logic signed [39:0] INT_MIN = {1'b1, 39'd0};

	vpid_in_t          in_q;
	logic signed [23:0] err_q, prev_q, avg_q;
	// error difference times weight can reach 25 bits
	logic signed [24:0] dot_q;
	logic signed [39:0] int_q;
	logic signed [47:0] acc_q;
	// sum of the three terms, integral term alone reaches about 51 bits
	logic signed [51:0] sum_q;
	vpid_out_t         out_q;

	// shared multiplier: 41-bit signed operand by 25-bit signed operand
	logic signed [40:0] ma;
	logic signed [24:0] mb;
	logic signed [65:0] prod;

	always_comb begin
		ma = '0;
		mb = '0;
		if (cmd.dot) begin
			ma = 41'(err_q) - 41'(prev_q);
			mb = $signed({9'd0, cfg.derivative_weight});
		end else if (cmd.integ) begin
			ma = 41'(err_q);
			mb = $signed({9'd0, cfg.tick_period});
		end else if (cmd.up) begin
			ma = 41'(err_q);
			mb = 25'(cfg.gain_p);
		end else if (cmd.ui) begin
			ma = 41'(int_q);
			mb = 25'(cfg.gain_i);
		end else begin
			ma = 41'(dot_q);
			mb = 25'(cfg.gain_d);
		end
		prod = 66'(ma) * 66'(mb);
	end

	logic signed [65:0] p16, p12;
	assign p16 = prod >>> 16;
	assign p12 = prod >>> 12;

	// error path
	logic signed [24:0] diff;
	logic signed [23:0] err_sat;
	logic signed [24:0] mag;
	logic [17:0]        db2, db3, band;
	logic signed [25:0] avg_sum;
	logic signed [25:0] avg_res;
	logic [25:0]        avg_abs;
	logic [25:0]        div3;
	logic signed [23:0] prev_div4;

	assign diff    = 25'(in_q.goal_velocity) - 25'(in_q.measured_velocity);
	assign err_sat = (diff > 25'sd8388607) ? 24'sh7FFFFF :
	                 (diff < -25'sd8388608) ? 24'sh800000 : diff[23:0];
	assign db2  = {1'b0, cfg.deadband, 1'b0};
	assign db3  = db2 + 18'(cfg.deadband);
	assign band = cfg.rule_set ? db3 : db2;

	always_comb begin
		mag       = err_q[23] ? -25'(err_q) : 25'(err_q);
		avg_sum   = 26'(err_q) + 26'(avg_q);
		avg_abs   = avg_sum[25] ? 26'(-avg_sum) : 26'(avg_sum);
		// divide by 3 via reciprocal: floor(x*43691 >> 17) exact for x < 2^17 only,
		// so use a wider reciprocal constant that is exact for 25-bit magnitudes
		div3      = 26'((52'(avg_abs) * 52'd11184811) >> 25);
		if (cfg.rule_set) avg_res = avg_sum[25] ? -$signed(div3) : $signed(div3);
		else              avg_res = avg_sum[25] ? -$signed(avg_abs >> 1)
		                                        : $signed(avg_abs >> 1);
		prev_div4 = prev_q[23] ? 24'(-((-25'(prev_q)) >>> 2)) : (prev_q >>> 2);
	end

	// accumulation
	logic signed [52:0] acc_sum;
	logic signed [47:0] acc_sat;
	logic [47:0]        acc_abs;
	logic [47:0]        raw;
	logic [16:0]        lim2;

	assign acc_sum = 53'(acc_q) + 53'(sum_q);
	assign acc_sat = (acc_sum > 53'(ACC_MAX)) ? ACC_MAX :
	                 (acc_sum < 53'(ACC_MIN)) ? ACC_MIN : acc_sum[47:0];

	always_comb begin
		acc_abs = acc_q[47] ? 48'(-acc_q) : 48'(acc_q);
		raw     = acc_abs >> FRAC_BITS;
		if (!cfg.rule_set && raw > 48'(MAG_CLAMP)) raw = 48'(MAG_CLAMP);
		lim2    = {cfg.duty_limit, 1'b0};
	end

	logic signed [41:0] int_sum;
	assign int_sum = 42'(int_q) + 42'(p16);

	assign stat.goal_zero = (in_q.goal_velocity == '0);
	assign dout = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			avg_q  <= '0;
			int_q  <= '0;
			acc_q  <= '0;
		end else begin
			if (cmd.shape) begin
				if (mag < 25'($signed({1'b0, cfg.deadband}))) begin
					if (cfg.rule_set) prev_q <= prev_div4;
				end else if (mag < $signed({7'd0, band})) begin
					avg_q <= avg_res[23:0];
				end
			end
			if (cmd.integ) begin
				int_q <= (int_sum > 42'(INT_MAX)) ? INT_MAX :
				         (int_sum < 42'(INT_MIN)) ? INT_MIN : int_sum[39:0];
				prev_q <= err_q;
			end
			if (cmd.acc) acc_q <= acc_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= din;
		if (cmd.err) begin
			err_q <= err_sat;
			out_q <= '{duty: 16'd0, output_negative: 1'b0,
			           over_twice_limit: 1'b0, stopped: 1'b1};
		end
		if (cmd.shape) begin
			if (mag < 25'($signed({1'b0, cfg.deadband})))
				err_q <= '0;
			else if (mag < $signed({7'd0, band}))
				err_q <= avg_res[23:0];
		end
		if (cmd.dot) dot_q <= p16[24:0];
		if (cmd.up)  sum_q <= 52'(p12);
		if (cmd.ui)  sum_q <= sum_q + 52'(p12);
		if (cmd.ud)  sum_q <= sum_q + 52'(p12);
		if (cmd.duty) begin
			out_q.stopped          <= 1'b0;
			out_q.output_negative  <= acc_q[47];
			out_q.over_twice_limit <= raw > 48'(lim2);
			out_q.duty <= (raw > 48'(cfg.duty_limit)) ? cfg.duty_limit : raw[15:0];
		end
	end
endmodule

// ----- hdl/velocity_pid_with_deadband.sv -----
// Velocity PID controller with deadband: top level.
//
// Usage: one request on the in channel (goal and measured velocity) yields
// one request on the out channel (duty, sign, over-limit flag, stopped).
// Both channels use valid/stall; a request moves when valid is high and
// stall is low. Configuration goes through the APB-style port, one 32-bit
// register per word, and must be written only while the block is idle;
// the block itself does not enforce this. One request is in flight at a
// time, set by the sequencer that walks the five products through the one
// shared 41x25 multiplier; for a zero goal it skips them and goes from the
// error step straight to the output. A new request is taken the cycle after
// the result leaves. Reset clears the controller state (previous error,
// average, integral, output accumulator) and loads the register defaults.
// While the out side stalls the result holds steady and the in channel
// stays stalled.
module velocity_pid_with_deadband import vpid_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int MAG_CLAMP = 150
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  vpid_in_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output vpid_out_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	vpid_cfg_t  cfg;
	vpid_cmd_t  cmd;
	vpid_stat_t stat;

	vpid_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	vpid_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.stat, .cmd
	);

	vpid_dp #(.FRAC_BITS(FRAC_BITS), .MAG_CLAMP(MAG_CLAMP)) u_dp (
		.clk, .arst_n, .din(in_data), .cfg, .cmd, .stat, .dout(out_data)
	);
endmodule

// ----- dv/velocity_pid_with_deadband_tb.sv -----
// Self-checking testbench for the velocity PID controller with deadband.
module velocity_pid_with_deadband_tb;
	import vpid_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int CLAMP = 150;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	vpid_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	vpid_out_t out_data;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	velocity_pid_with_deadband dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// controller copy
	logic rule_m;
	logic signed [23:0] kp, ki, kd;
	logic [15:0] dt_m, dw_m, band_m, lim_m;
	longint prev_err, err_avg, err_int, out_acc;

	vpid_in_t pending_requests[$];
	vpid_out_t expected_duty[$];
	int send_idle_pct, recv_idle_pct;
	int errors, accepted_in, accepted_out, stopped_seen, over_seen, idle_cycles;

	function automatic longint clip(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	// $signed shift of longint is arithmetic, i.e. floor
	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic vpid_out_t pid_step(vpid_in_t r);
		longint g, m, e, mag, dot, up, ui, ud, acc, raw, lim;
		vpid_out_t o;
		g = r.goal_velocity;
		m = r.measured_velocity;
		o = '0;
		if (g == 0) begin
			o.stopped = 1'b1;
			return o;
		end
		e = clip(g - m, 24);
		mag = e < 0 ? -e : e;
		if (mag < longint'(band_m)) begin
			e = 0;
			if (rule_m)
				prev_err = prev_err / 4;
		end else if (mag < longint'(band_m) * (rule_m ? 3 : 2)) begin
			err_avg = (e + err_avg) / (rule_m ? 3 : 2);
			e = err_avg;
		end
		dot = floor_shr((e - prev_err) * longint'(dw_m), 16);
		err_int = clip(err_int + floor_shr(e * longint'(dt_m), 16), 40);
		up = floor_shr(longint'(kp) * e, 12);
		ui = floor_shr(longint'(ki) * err_int, 12);
		ud = floor_shr(longint'(kd) * dot, 12);
		prev_err = e;
		acc = clip(out_acc + up + ui + ud, 48);
		out_acc = acc;
		raw = (acc < 0 ? -acc : acc) >>> FRAC;
		if (!rule_m && raw > CLAMP)
			raw = CLAMP;
		lim = lim_m;
		if (raw > 2 * lim) begin
			o.duty = lim[15:0];
			o.over_twice_limit = 1'b1;
		end else if (raw > lim)
			o.duty = lim[15:0];
		else
			o.duty = raw[15:0];
		o.output_negative = acc < 0;
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!in_valid || !in_stall) begin
			if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_requests.pop_front();
			end else
				in_valid <= 1'b0;
		end
		out_stall <= $urandom_range(99) < recv_idle_pct;
	end

	// monitor, scoreboard and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ?
				0 : idle_cycles + 1;
			if (in_valid && !in_stall) begin
				expected_duty.push_back(pid_step(in_data));
				accepted_in <= accepted_in + 1;
			end
			if (out_valid && !out_stall) begin
				vpid_out_t x;
				accepted_out <= accepted_out + 1;
				if (expected_duty.size() == 0) begin
					$error("result with no request pending");
					errors++;
				end else begin
					x = expected_duty.pop_front();
					if (out_data.duty !== x.duty) begin
						$error("duty exp %0d got %0d", x.duty, out_data.duty);
						errors++;
					end
					if (out_data.output_negative !== x.output_negative) begin
						$error("output_negative exp %0d got %0d", x.output_negative,
							out_data.output_negative);
						errors++;
					end
					if (out_data.over_twice_limit !== x.over_twice_limit) begin
						$error("over_twice_limit exp %0d got %0d", x.over_twice_limit,
							out_data.over_twice_limit);
						errors++;
					end
					if (out_data.stopped !== x.stopped) begin
						$error("stopped exp %0d got %0d", x.stopped, out_data.stopped);
						errors++;
					end
					stopped_seen += x.stopped;
					over_seen += x.over_twice_limit;
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired, %0d results outstanding", expected_duty.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic reg_write(vpid_reg_t idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RULE_SET: rule_m = v[0];
			REG_GAIN_P:   kp = v[23:0];
			REG_GAIN_I:   ki = v[23:0];
			REG_GAIN_D:   kd = v[23:0];
			REG_TICK:     dt_m = v[15:0];
			REG_DWEIGHT:  dw_m = v[15:0];
			REG_DEADBAND: band_m = v[15:0];
			REG_DUTY_LIM: lim_m = v[15:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		wait (pending_requests.size() == 0);
		@(posedge clk);
		while (in_valid || expected_duty.size() != 0)
			@(posedge clk);
		repeat (15) @(posedge clk);
	endtask

	task automatic queue_request(logic [23:0] g, logic [23:0] m);
		vpid_in_t r;
		r.goal_velocity = g;
		r.measured_velocity = m;
		pending_requests.push_back(r);
	endtask

	task automatic random_setup(bit extreme);
		reg_write(REG_RULE_SET, $urandom_range(1));
		reg_write(REG_GAIN_P, extreme ? ($urandom_range(1) ? 32'h7FFFFF : 32'h800000)
			: $urandom_range(8192));
		reg_write(REG_GAIN_I, extreme ? 32'h800000 : $urandom_range(2048));
		reg_write(REG_GAIN_D, extreme ? 32'h7FFFFF : $urandom);
		reg_write(REG_TICK, extreme ? 16'hFFFF : $urandom_range(65535));
		reg_write(REG_DWEIGHT, extreme ? 16'hFFFF : $urandom_range(65535));
		reg_write(REG_DEADBAND, extreme ? 16'hFFFF : $urandom_range(4000));
		reg_write(REG_DUTY_LIM, extreme ? 0 : $urandom_range(300));
	endtask

	// mostly errors near the deadband edges, some full-range noise
	task automatic random_batch(int n);
		logic [23:0] g, m;
		int d;
		repeat (n) begin
			g = $urandom;
			case ($urandom_range(9))
				0: g = 24'd0;
				1, 2: m = $urandom;
				default: begin
					d = $urandom_range(4 * band_m + 2);
					m = g - ($urandom_range(1) ? d : -d);
				end
			endcase
			if (g == 0 || $urandom_range(9) == 0)
				m = $urandom;
			queue_request(g, m);
		end
	endtask

	initial begin
		errors = 0; accepted_in = 0; accepted_out = 0;
		stopped_seen = 0; over_seen = 0; idle_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rule_m = 1'b0; kp = '0; ki = '0; kd = '0;
		dt_m = 16'd6554; dw_m = 16'd60713; band_m = 16'd655; lim_m = 16'd255;
		prev_err = 0; err_avg = 0; err_int = 0; out_acc = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// defaults with zero gains, then field extremes
		queue_request(24'h000000, 24'h123456);
		queue_request(24'h7FFFFF, 24'h800000);
		drain();
		reg_write(REG_GAIN_P, 32'h001000);
		reg_write(REG_GAIN_I, 32'h000400);
		reg_write(REG_GAIN_D, 32'h000200);
		queue_request(24'h800000, 24'h7FFFFF);
		queue_request(24'h7FFFFF, 24'h7FFFFF);
		queue_request(24'h000400, 24'h000100);  // averaging band
		queue_request(24'h000400, 24'h000000);  // averaging band
		queue_request(24'h000800, 24'h000000);  // beyond band
		queue_request(24'hFFFFFF, 24'h000000);
		queue_request(24'h000000, 24'hFFFFFF);
		drain();
		reg_write(REG_RULE_SET, 1);
		queue_request(24'h000400, 24'h000100);  // averaging band
		queue_request(24'h000400, 24'hFFFE00);
		queue_request(24'h050000, 24'h000000);
		queue_request(24'hF00000, 24'h000000);
		drain();
		reg_write(REG_DUTY_LIM, 0);
		queue_request(24'h7FFFFF, 24'h000000);
		queue_request(24'h800001, 24'h000000);
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			send_idle_pct = ph < 3 ? 11 : (ph < 6 ? 79 : 0);
			recv_idle_pct = ph < 3 ? 79 : (ph < 6 ? 11 : 0);
			random_setup(ph == 4 || ph == 7);
			random_batch(ph == 4 || ph == 7 ? 30 : 80);
			drain();
		end
		reg_write(REG_RULE_SET, 0);
		reg_write(REG_DEADBAND, 0);
		reg_write(REG_DUTY_LIM, 16'hFFFF);
		random_batch(40);
		drain();

		$display("requests in %0d, results checked %0d (stopped %0d, over-limit %0d)",
			accepted_in, accepted_out, stopped_seen, over_seen);
		$display("both rule sets, extreme gains and limits, three idle/stall mixes");
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
